FILE: src/bmt_pkg.sv
`default_nettype none

package bmt_pkg;

    // Default size of the byte memory.
    localparam int MEM_BYTES_DEF = 4096;

    // Largest burst, in bytes.
    localparam int MAX_BURST = 8;

    // Value of an enabled byte in the byte-enable pattern.
    localparam logic [7:0] BE_ON = 8'hFF;

    typedef enum logic [1:0] {
        MODE_IGNORE  = 2'd0,
        MODE_READ    = 2'd1,
        MODE_WRITE   = 2'd2,
        MODE_INVALID = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_CMD   = 3'd1,
        ST_BURST = 3'd2,
        ST_BE    = 3'd3,
        ST_ADDR  = 3'd4
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic load;
        logic check;
        logic step;
        logic publish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic go;
        logic last;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: src/burst_memory_target.sv
`default_nettype none

// Byte memory target that serves one burst transaction per input beat and
// returns one result beat per transaction. A transaction is checked in this
// order: ignore (ok, data echoed), unknown command, zero or oversized length
// or zero wrap width, byte-enable bytes other than 0 or 255, and a span
// that leaves the memory; the first failure sets the status and leaves the
// memory untouched. A valid read or write moves each enabled burst byte i at
// address + (i mod wrap_width), with the enable pattern repeating every
// enable_len bytes. Disabled read bytes return the input data, and bytes above
// the burst length read as zero. After reset the block zeroes the whole
// memory, with in_ready low. An ignored or failed transaction passes through
// a check state and then the done state, which loads the result register; a
// good read or write goes from the check state through one access step per
// burst byte, since the byte-wide memory moves one burst byte per cycle, and
// a drain state in which the last registered read lands, to the done state.
// The done state loads the result register only once no earlier result is
// still waiting to be taken. The next beat is taken in the cycle after the
// result is loaded. The result register holds one finished result, so a new
// beat is taken while the previous result waits.

module burst_memory_target #(
    parameter int MEM_BYTES = bmt_pkg::MEM_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [31:0] address,
    input  wire logic [3:0]  data_len,
    input  wire logic [7:0]  wrap_width,
    input  wire logic [63:0] write_data,
    input  wire logic [63:0] enable_pattern,
    input  wire logic [3:0]  enable_len,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [2:0]  status,
    output logic      [63:0] read_data
);

    import bmt_pkg::*;

    // Command and status between the sequencer and the datapath.
    cmd_t     cmd;
    dp_stat_t stat;

    bmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the captured transaction, the validation logic, the
    // byte counters with their wrap logic, the memory and the result register.
    bmt_datapath #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .mode            (mode),
        .address         (address),
        .data_len        (data_len),
        .wrap_width      (wrap_width),
        .write_data      (write_data),
        .enable_pattern  (enable_pattern),
        .enable_len      (enable_len),
        .status          (status),
        .read_data       (read_data)
    );

endmodule

`default_nettype wire

FILE: src/bmt_ram.sv
`default_nettype none

module bmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/bmt_datapath.sv
`default_nettype none

module bmt_datapath #(
    parameter int MEM_BYTES = bmt_pkg::MEM_BYTES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bmt_pkg::cmd_t    cmd,
    output bmt_pkg::dp_stat_t     stat,
    input  wire logic [1:0]       mode,
    input  wire logic [31:0]      address,
    input  wire logic [3:0]       data_len,
    input  wire logic [7:0]       wrap_width,
    input  wire logic [63:0]      write_data,
    input  wire logic [63:0]      enable_pattern,
    input  wire logic [3:0]       enable_len,
    output logic      [2:0]       status,
    output logic      [63:0]      read_data
);

    import bmt_pkg::*;

    localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

    // Captured transaction.
    mode_t       mode_reg;
    logic [31:0] addr_reg;
    logic [3:0]  len_reg;
    logic [7:0]  sw_reg;
    logic [63:0] wdata_reg;
    logic [63:0] pat_reg;
    logic [3:0]  plen_reg;

    // Working state.
    status_t     status_reg, status_next;
    logic [63:0] res_reg, res_next;
    logic [2:0]  idx_reg, idx_next;
    logic [7:0]  off_reg, off_next;
    logic [2:0]  pj_reg, pj_next;
    logic        pend_reg, pend_next;
    logic [2:0]  pidx_reg, pidx_next;
    logic [AW-1:0] clr_reg, clr_next;

    // Result register.
    logic [2:0]  out_status_reg;
    logic [63:0] out_data_reg;

    logic [3:0]  nb;
    logic [7:0]  span;
    logic [32:0] addr_end;
    logic        be_bad;
    status_t     chk_status;
    logic [63:0] echo;
    logic        byte_en;
    logic [AW-1:0] acc_addr;
    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]  ram_wdata;
    logic [7:0]  ram_rdata;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= mode_t'(mode);
            addr_reg  <= address;
            len_reg   <= data_len;
            sw_reg    <= wrap_width;
            wdata_reg <= write_data;
            pat_reg   <= enable_pattern;
            plen_reg  <= (enable_len > 4'd8) ? 4'd8 : enable_len;
        end
        if (cmd.publish)
        begin
            out_status_reg <= status_reg;
            out_data_reg   <= res_reg;
        end
        status_reg <= status_next;
        res_reg    <= res_next;
        idx_reg    <= idx_next;
        off_reg    <= off_next;
        pj_reg     <= pj_next;
        pidx_reg   <= pidx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            clr_reg  <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            clr_reg  <= clr_next;
        end
    end

    // Validation of the captured transaction.
    always_comb
    begin
        nb       = (len_reg > 4'(MAX_BURST)) ? 4'(MAX_BURST) : len_reg;
        span     = ({4'd0, len_reg} < sw_reg) ? {4'd0, len_reg} : sw_reg;
        addr_end = {1'b0, addr_reg} + 33'(span);
        be_bad   = 1'b0;
        for (int j = 0; j < 8; j++)
        begin
            if ((4'(j) < plen_reg) && (pat_reg[8*j +: 8] != 8'd0)
                && (pat_reg[8*j +: 8] != BE_ON))
            begin
                be_bad = 1'b1;
            end
        end
        for (int i = 0; i < 8; i++)
        begin
            echo[8*i +: 8] = (4'(i) < nb) ? wdata_reg[8*i +: 8] : 8'd0;
        end
        if (mode_reg == MODE_IGNORE)
        begin
            chk_status = ST_OK;
        end
        else if (mode_reg == MODE_INVALID)
        begin
            chk_status = ST_CMD;
        end
        else if ((len_reg == 4'd0) || (len_reg > 4'(MAX_BURST)) || (sw_reg == 8'd0))
        begin
            chk_status = ST_BURST;
        end
        else if (be_bad)
        begin
            chk_status = ST_BE;
        end
        else if (addr_end > 33'(MEM_BYTES))
        begin
            chk_status = ST_ADDR;
        end
        else
        begin
            chk_status = ST_OK;
        end
    end

    assign byte_en  = (plen_reg == 4'd0) || (pat_reg[8*pj_reg +: 8] != 8'd0);
    assign acc_addr = addr_reg[AW-1:0] + AW'(off_reg);

    always_comb
    begin
        status_next = status_reg;
        res_next    = res_reg;
        idx_next    = idx_reg;
        off_next    = off_reg;
        pj_next     = pj_reg;
        pend_next   = 1'b0;
        pidx_next   = pidx_reg;
        clr_next    = clr_reg;
        ram_we      = 1'b0;
        ram_waddr   = acc_addr;
        ram_wdata   = wdata_reg[8*idx_reg +: 8];

        // A read issued last cycle lands now.
        if (pend_reg)
        begin
            res_next[8*pidx_reg +: 8] = ram_rdata;
        end

        if (cmd.clear)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = 8'd0;
            clr_next  = clr_reg + AW'(1);
        end

        if (cmd.check)
        begin
            status_next = chk_status;
            res_next    = echo;
            idx_next    = 3'd0;
            off_next    = 8'd0;
            pj_next     = 3'd0;
        end

        if (cmd.step)
        begin
            if (byte_en)
            begin
                if (mode_reg == MODE_READ)
                begin
                    pend_next = 1'b1;
                    pidx_next = idx_reg;
                end
                else
                begin
                    ram_we = 1'b1;
                end
            end
            idx_next = idx_reg + 3'd1;
            off_next = ({1'b0, off_reg} + 9'd1 == {1'b0, sw_reg}) ? 8'd0 : off_reg + 8'd1;
            pj_next  = ({1'b0, pj_reg} + 4'd1 == plen_reg) ? 3'd0 : pj_reg + 3'd1;
        end
    end

    bmt_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (acc_addr),
        .rdata (ram_rdata)
    );

    assign stat.clr_last = (clr_reg == AW'(MEM_BYTES - 1));
    assign stat.go       = (chk_status == ST_OK) && (mode_reg != MODE_IGNORE);
    assign stat.last     = ({1'b0, idx_reg} + 4'd1 == nb);

    assign status    = out_status_reg;
    assign read_data = out_data_reg;

endmodule

`default_nettype wire

FILE: src/bmt_ctrl.sv
`default_nettype none

module bmt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire bmt_pkg::dp_stat_t stat,
    output bmt_pkg::cmd_t          cmd
);

    import bmt_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_CHECK  = 6'b000100,
        S_ACCESS = 6'b001000,
        S_DRAIN  = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = stat.go ? S_ACCESS : S_DONE;
            end
            S_ACCESS:
            begin
                cmd.step = 1'b1;
                if (stat.last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: src/bmt_checker.sv
`default_nettype none

module bmt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  status,
    input wire logic [63:0] read_data
);

    import bmt_pkg::*;

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_data))
    else $error("result changed while stalled");

    // The block works on one transaction at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("beat accepted while a transaction is in flight");

    // Only defined status codes leave the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_ADDR)
    else $error("undefined status code");

endmodule

bind burst_memory_target bmt_checker u_bmt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .read_data (read_data)
);

`default_nettype wire
